@@ sv/qrs_pkg.sv @@
package qrs_pkg;

    localparam int COEF_W     = 16;
    localparam int ROOT_OUT_W = 40;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int DISC_W     = PROD_W + 3;
    localparam int RAD_W      = 50;
    localparam int SQRT_W     = RAD_W / 2;
    localparam int NUM_W      = 36;
    localparam int DVD_W      = NUM_W - 1;
    localparam int DEN_W      = COEF_W + 2;
    localparam int DVS_W      = DEN_W - 1;
    localparam int CASE_W     = 3;

    typedef enum logic [CASE_W-1:0] {
        CASE_TWO      = 3'd0,
        CASE_ONE      = 3'd1,
        CASE_COMPLEX  = 3'd2,
        CASE_LINEAR   = 3'd3,
        CASE_INFINITE = 3'd4,
        CASE_NONE     = 3'd5
    } case_t;

    // Sideband that rides alongside the square root pipeline.
    typedef struct packed {
        logic                     valid;
        case_t                    code;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } sq_side_t;

    // Sideband that rides alongside the divider pipelines.
    typedef struct packed {
        logic  valid;
        case_t code;
        logic  neg1;
        logic  neg2;
    } dv_side_t;

endpackage

@@ sv/qrs_if.sv @@
interface qrs_coef_if;
    import qrs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coef_quad;
    logic signed [COEF_W-1:0] coef_lin;
    logic signed [COEF_W-1:0] coef_const;

    modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
    modport sink (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

interface qrs_root_if;
    import qrs_pkg::*;
    logic                         valid;
    logic                         ready;
    logic        [CASE_W-1:0]     root_case;
    logic signed [ROOT_OUT_W-1:0] root_first;
    logic signed [ROOT_OUT_W-1:0] root_second;

    modport source (output valid, root_case, root_first, root_second, input ready);
    modport sink (input valid, root_case, root_first, root_second, output ready);
endinterface

@@ sv/qrs_sqrt.sv @@
module qrs_sqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [qrs_pkg::RAD_W-1:0]  radicand,
    output logic [qrs_pkg::SQRT_W-1:0] root
);
    import qrs_pkg::*;

    localparam int REM_W = SQRT_W + 3;

    // One result bit per stage, restoring digit-by-digit method.
    logic [RAD_W-1:0]  rad_reg  [SQRT_W];
    logic [REM_W-1:0]  rem_reg  [SQRT_W];
    logic [SQRT_W-1:0] root_reg [SQRT_W];
    logic [RAD_W-1:0]  rad_next  [SQRT_W];
    logic [REM_W-1:0]  rem_next  [SQRT_W];
    logic [SQRT_W-1:0] root_next [SQRT_W];

    always_comb
    begin
        logic [RAD_W-1:0]  prev_rad;
        logic [REM_W-1:0]  prev_rem;
        logic [SQRT_W-1:0] prev_root;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        for (int k = 0; k < SQRT_W; k++)
        begin
            if (k == 0)
            begin
                prev_rad  = radicand;
                prev_rem  = '0;
                prev_root = '0;
            end
            else
            begin
                prev_rad  = rad_reg[k-1];
                prev_rem  = rem_reg[k-1];
                prev_root = root_reg[k-1];
            end
            rem_sh      = {prev_rem[REM_W-3:0], prev_rad[RAD_W-1 -: 2]};
            trial       = {1'b0, prev_root, 2'b01};
            rad_next[k] = {prev_rad[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next[k]  = rem_sh - trial;
                root_next[k] = {prev_root[SQRT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh;
                root_next[k] = {prev_root[SQRT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_W; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[SQRT_W-1];

endmodule

@@ sv/qrs_div.sv @@
module qrs_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [qrs_pkg::DVD_W-1:0] dividend,
    input  logic [qrs_pkg::DVS_W-1:0] divisor,
    output logic [qrs_pkg::DVD_W-1:0] quotient
);
    import qrs_pkg::*;

    // Unsigned restoring division, one quotient bit per stage. The dividend
    // shifts out of the top of dq while quotient bits shift in at the bottom.
    logic [DVD_W-1:0] dq_reg   [DVD_W];
    logic [DVS_W-1:0] rem_reg  [DVD_W];
    logic [DVS_W-1:0] dvs_reg  [DVD_W];
    logic [DVD_W-1:0] dq_next  [DVD_W];
    logic [DVS_W-1:0] rem_next [DVD_W];
    logic [DVS_W-1:0] dvs_next [DVD_W];

    always_comb
    begin
        logic [DVD_W-1:0] prev_dq;
        logic [DVS_W-1:0] prev_rem;
        logic [DVS_W-1:0] prev_dvs;
        logic [DVS_W:0]   rem_sh;
        logic [DVS_W:0]   diff;
        for (int k = 0; k < DVD_W; k++)
        begin
            if (k == 0)
            begin
                prev_dq  = dividend;
                prev_rem = '0;
                prev_dvs = divisor;
            end
            else
            begin
                prev_dq  = dq_reg[k-1];
                prev_rem = rem_reg[k-1];
                prev_dvs = dvs_reg[k-1];
            end
            rem_sh      = {prev_rem, prev_dq[DVD_W-1]};
            diff        = rem_sh - {1'b0, prev_dvs};
            dvs_next[k] = prev_dvs;
            if (rem_sh >= {1'b0, prev_dvs})
            begin
                rem_next[k] = diff[DVS_W-1:0];
                dq_next[k]  = {prev_dq[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rem_sh[DVS_W-1:0];
                dq_next[k]  = {prev_dq[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DVD_W; k++)
            begin
                dq_reg[k]  <= dq_next[k];
                rem_reg[k] <= rem_next[k];
                dvs_reg[k] <= dvs_next[k];
            end
        end
    end

    assign quotient = dq_reg[DVD_W-1];

endmodule

@@ sv/quadratic_root_solver.sv @@
// Quadratic root solver for a*x^2 + b*x + c = 0, real roots only.
//
// The coef channel carries the three coefficients in signed Q8.8. For each
// transfer on coef the block returns exactly one transfer on roots: a case
// code (two roots, one root, complex, linear, infinite, none) and up to two
// roots in signed Q24.16. Absent roots are zero. The square root is floored
// and every quotient is truncated toward zero.
//
// The datapath is one pipeline: input register, two multipliers, the
// discriminant, a 25-stage square root (one root bit per stage), a numerator
// stage, two 35-stage dividers (one quotient bit per stage) and the output
// register. A new item can be taken every cycle, so throughput is one item
// per cycle while roots is ready.
//
// When the receiver holds roots.ready low while a result is shown, the whole
// pipeline freezes, coef.ready drops, and nothing is lost or repeated; items
// in flight resume where they stopped. Reset clears all valid bits, so the
// pipeline comes out of reset empty and ready.
module quadratic_root_solver (
    input  logic       clk,
    input  logic       rst_n,
    qrs_coef_if.sink   coef,
    qrs_root_if.source roots
);
    import qrs_pkg::*;

    // The pipeline advances whenever the output register is empty or drained.
    logic en;
    logic out_valid_reg;

    assign en         = !out_valid_reg || roots.ready;
    assign coef.ready = en;

    // Input register.
    logic                     v0_reg;
    logic signed [COEF_W-1:0] a0_reg, b0_reg, c0_reg;

    // Products.
    logic                     v1_reg;
    logic signed [COEF_W-1:0] a1_reg, b1_reg, c1_reg;
    logic signed [PROD_W-1:0] bb1_reg, ac1_reg;

    // Discriminant and case decision.
    logic signed [DISC_W-1:0] disc;
    case_t                    code2;
    sq_side_t                 side2_next, side2_reg;
    logic [RAD_W-1:0]         rad2_next, rad2_reg;

    always_comb
    begin
        disc = {{3{bb1_reg[PROD_W-1]}}, bb1_reg} - {ac1_reg[PROD_W-1], ac1_reg, 2'b00};
        if (a1_reg == '0)
        begin
            if (b1_reg != '0)
                code2 = CASE_LINEAR;
            else if (c1_reg == '0)
                code2 = CASE_INFINITE;
            else
                code2 = CASE_NONE;
        end
        else if (disc[DISC_W-1])
            code2 = CASE_COMPLEX;
        else if (disc == '0)
            code2 = CASE_ONE;
        else
            code2 = CASE_TWO;

        side2_next = '{valid: v1_reg, code: code2, a: a1_reg, b: b1_reg, c: c1_reg};
        // A positive discriminant stays below 2^33, so the radicand D * 2^16 fits.
        if (code2 == CASE_TWO)
            rad2_next = {1'b0, disc[DISC_W-3:0], 16'b0};
        else
            rad2_next = '0;
    end

    // Square root, with the sideband delayed to match.
    logic [SQRT_W-1:0] sqrt_root;
    sq_side_t          side_sq_reg [SQRT_W];

    qrs_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (rad2_reg),
        .root     (sqrt_root)
    );

    // Numerators and denominators, split into magnitude and sign.
    sq_side_t                sd;
    logic signed [NUM_W-1:0] nb, s_ext, n1, n2, n1_abs, n2_abs;
    logic signed [DEN_W-1:0] den, den_abs;
    dv_side_t                side_nm_next, side_nm_reg;
    logic [DVD_W-1:0]        dvd1_reg, dvd2_reg;
    logic [DVS_W-1:0]        dvs_reg;

    always_comb
    begin
        sd    = side_sq_reg[SQRT_W-1];
        nb    = -$signed({{(NUM_W-COEF_W-8){sd.b[COEF_W-1]}}, sd.b, 8'b0});
        s_ext = $signed({{(NUM_W-SQRT_W){1'b0}}, sqrt_root});
        case (sd.code)
            CASE_TWO:
            begin
                n1  = (nb + s_ext) <<< 8;
                n2  = (nb - s_ext) <<< 8;
                den = $signed({sd.a[COEF_W-1], sd.a, 1'b0});
            end
            CASE_ONE:
            begin
                n1  = nb <<< 8;
                n2  = '0;
                den = $signed({sd.a[COEF_W-1], sd.a, 1'b0});
            end
            CASE_LINEAR:
            begin
                n1  = -$signed({{(NUM_W-COEF_W-16){sd.c[COEF_W-1]}}, sd.c, 16'b0});
                n2  = '0;
                den = $signed({{2{sd.b[COEF_W-1]}}, sd.b});
            end
            default:
            begin
                n1  = '0;
                n2  = '0;
                den = $signed({{(DEN_W-1){1'b0}}, 1'b1});
            end
        endcase
        n1_abs  = n1[NUM_W-1] ? -n1 : n1;
        n2_abs  = n2[NUM_W-1] ? -n2 : n2;
        den_abs = den[DEN_W-1] ? -den : den;
        side_nm_next = '{valid: sd.valid, code: sd.code,
                         neg1: n1[NUM_W-1] ^ den[DEN_W-1],
                         neg2: n2[NUM_W-1] ^ den[DEN_W-1]};
    end

    // Dividers, with the sideband delayed to match.
    logic [DVD_W-1:0] q1, q2;
    dv_side_t         side_dv_reg [DVD_W];

    qrs_div u_div_first (
        .clk      (clk),
        .en       (en),
        .dividend (dvd1_reg),
        .divisor  (dvs_reg),
        .quotient (q1)
    );

    qrs_div u_div_second (
        .clk      (clk),
        .en       (en),
        .dividend (dvd2_reg),
        .divisor  (dvs_reg),
        .quotient (q2)
    );

    // Output stage: restore the sign of each quotient.
    dv_side_t                     so;
    logic signed [ROOT_OUT_W-1:0] r1_next, r2_next, r1_reg, r2_reg;
    logic [CASE_W-1:0]            case_reg;

    always_comb
    begin
        so      = side_dv_reg[DVD_W-1];
        r1_next = {{(ROOT_OUT_W-DVD_W){1'b0}}, q1};
        r2_next = {{(ROOT_OUT_W-DVD_W){1'b0}}, q2};
        if (so.neg1)
            r1_next = -r1_next;
        if (so.neg2)
            r2_next = -r2_next;
    end

    // Control state: valid bits and the sidebands that carry them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            side2_reg     <= '0;
            side_nm_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SQRT_W; k++)
                side_sq_reg[k] <= '0;
            for (int k = 0; k < DVD_W; k++)
                side_dv_reg[k] <= '0;
        end
        else if (en)
        begin
            v0_reg         <= coef.valid;
            v1_reg         <= v0_reg;
            side2_reg      <= side2_next;
            side_sq_reg[0] <= side2_reg;
            for (int k = 1; k < SQRT_W; k++)
                side_sq_reg[k] <= side_sq_reg[k-1];
            side_nm_reg    <= side_nm_next;
            side_dv_reg[0] <= side_nm_reg;
            for (int k = 1; k < DVD_W; k++)
                side_dv_reg[k] <= side_dv_reg[k-1];
            out_valid_reg  <= so.valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg   <= coef.coef_quad;
            b0_reg   <= coef.coef_lin;
            c0_reg   <= coef.coef_const;
            a1_reg   <= a0_reg;
            b1_reg   <= b0_reg;
            c1_reg   <= c0_reg;
            bb1_reg  <= b0_reg * b0_reg;
            ac1_reg  <= a0_reg * c0_reg;
            rad2_reg <= rad2_next;
            dvd1_reg <= n1_abs[DVD_W-1:0];
            dvd2_reg <= n2_abs[DVD_W-1:0];
            dvs_reg  <= den_abs[DVS_W-1:0];
            case_reg <= so.code;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
        end
    end

    assign roots.valid       = out_valid_reg;
    assign roots.root_case   = case_reg;
    assign roots.root_first  = r1_reg;
    assign roots.root_second = r2_reg;

    // Only the two-root case may carry a second root.
    a_second_only_two: assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid && roots.root_case != CASE_TWO |-> roots.root_second == '0)
        else $error("second root set outside the two-root case");

    // Cases without a root must show a zero first root.
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid && (roots.root_case == CASE_COMPLEX ||
                        roots.root_case == CASE_INFINITE ||
                        roots.root_case == CASE_NONE)
        |-> roots.root_first == '0)
        else $error("first root set in a case without roots");

    // Input back-pressure only comes from a stalled, full output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !coef.ready |-> roots.valid && !roots.ready)
        else $error("input stalled without an output stall");

endmodule
